// ===== hw/rtl/hpr_pkg.sv =====
// ----------------------------------------------------------------------------
// hpr_pkg: shared types and constants of the hall pass rpm meter
// Holds register widths and indexes, reset values, the sequencer states and
// the status bundle of the divider.
// ----------------------------------------------------------------------------
package hpr_pkg;

  localparam int unsigned RATE_BITS  = 16;
  localparam int unsigned LEVEL_BITS = 10;
  localparam int unsigned TOP_BITS   = 16;
  localparam int unsigned DATA_BITS  = 16;
  localparam int unsigned RPM_BITS   = 22;

  // Product 120 * ticks_per_second fits this many bits.
  localparam int unsigned SCALED_BITS = 23;

  localparam logic [RATE_BITS-1:0]   TPS_RESET  = 16'd12000;
  localparam logic [LEVEL_BITS-1:0]  RISE_RESET = 10'd450;
  localparam logic [LEVEL_BITS-1:0]  FALL_RESET = 10'd417;
  localparam logic [TOP_BITS-1:0]    TOP_RESET  = 16'd65535;
  localparam logic [SCALED_BITS-1:0] RPM_SCALE  = 23'd120;
  localparam logic [RPM_BITS-1:0]    RPM_MAX    = 22'd4194303;

  typedef enum logic [1:0] {
    CFG_TPS  = 2'd0,
    CFG_RISE = 2'd1,
    CFG_FALL = 2'd2,
    CFG_TOP  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_WAIT = 2'd2
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== hw/rtl/hall_pass_rpm_meter.sv =====
// ----------------------------------------------------------------------------
// hall_pass_rpm_meter: period-measuring tachometer
// Counts timer ticks between two magnet passes and reports rounded rpm.
// ----------------------------------------------------------------------------
// Usage:
// Each input request carries op (0 = one timer tick, 1 = one sensor sample)
// and a sample value. A request is taken when in_valid_i is high and
// in_stall_o is low. Ticks and samples that do not end a measurement leave
// the block idle and ready for the next request.
// Every second magnet pass ends a measurement and produces one result
// request: rpm = round(60 * ticks_per_second / period). For a nonzero
// period a shared restoring divider produces one quotient bit per cycle,
// and in_stall_o stays high until the result is in the output register.
// A zero period skips the divider and reports the maximum rpm with
// zero_period set.
// The result sits in an output register; if the receiver stalls, further
// ticks and samples are still taken, and only a following result waits
// (with in_stall_o high) until the register is free.
// The configuration port is always ready and must be written only while the
// block is idle. Reset restores the register defaults, clears the tick
// counter, the pass parity and the magnet latch, and drops any result.
// ----------------------------------------------------------------------------
module hall_pass_rpm_meter
  import hpr_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10,
  parameter int unsigned TIMER_BITS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input requests
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   in_op_i,
  input  logic [SAMPLE_BITS-1:0] in_sample_i,
  // result requests
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [RPM_BITS-1:0]    out_rpm_o,
  output logic                   out_zero_period_o,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  cfg_idx_e               cfg_index_i,
  input  logic [DATA_BITS-1:0]   cfg_data_i
);

  // Comparison widths that cover both sides of each compare.
  localparam int unsigned LVL_W = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
  localparam int unsigned CNT_W = (TIMER_BITS > TOP_BITS) ? TIMER_BITS : TOP_BITS;
  // The numerator 120 * rate + period needs one bit above the wider term.
  localparam int unsigned NUM_BITS =
    ((TIMER_BITS > SCALED_BITS) ? TIMER_BITS : SCALED_BITS) + 1;
  localparam int unsigned DEN_BITS = TIMER_BITS + 1;

  // Configuration registers.
  logic [RATE_BITS-1:0]  tps_q;
  logic [LEVEL_BITS-1:0] rise_q;
  logic [LEVEL_BITS-1:0] fall_q;
  logic [TOP_BITS-1:0]   top_q;

  // Measurement state.
  logic [TIMER_BITS-1:0] tick_q, tick_d;
  logic                  parity_q, parity_d;
  logic                  latched_q, latched_d;
  state_e                state_q, state_d;
  logic                  zero_pend_q, zero_pend_d;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic [RPM_BITS-1:0]   rpm_q, rpm_d;
  logic                  zero_q, zero_d;

  logic                  in_accept;
  logic                  slot_free;
  logic                  is_pass;
  logic                  capture;
  logic                  div_start;
  logic [LVL_W-1:0]      smp_ext;
  logic [CNT_W-1:0]      tick_ext;
  logic [SCALED_BITS-1:0] scaled_tps;
  logic [NUM_BITS-1:0]   div_num;
  logic [DEN_BITS-1:0]   div_den;
  logic [RPM_BITS-1:0]   div_quot;
  div_status_t           div_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q  <= TPS_RESET;
      rise_q <= RISE_RESET;
      fall_q <= FALL_RESET;
      top_q  <= TOP_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TPS:  tps_q  <= cfg_data_i[RATE_BITS-1:0];
        CFG_RISE: rise_q <= cfg_data_i[LEVEL_BITS-1:0];
        CFG_FALL: fall_q <= cfg_data_i[LEVEL_BITS-1:0];
        CFG_TOP:  top_q  <= cfg_data_i[TOP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input requests are taken only while the sequencer is idle.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign smp_ext    = LVL_W'(in_sample_i);
  assign tick_ext   = CNT_W'(tick_q);

  // A pass is a sample at or above the rise level while no magnet is latched.
  assign is_pass = in_op_i && !latched_q && (smp_ext >= LVL_W'(rise_q));
  // Every second pass closes a measurement.
  assign capture   = in_accept && is_pass && parity_q;
  assign div_start = capture && (tick_q != '0);

  // Rounded quotient: floor((120 * rate + period) / (2 * period)).
  assign scaled_tps = SCALED_BITS'(tps_q) * RPM_SCALE;
  assign div_num    = NUM_BITS'(scaled_tps) + NUM_BITS'(tick_q);
  assign div_den    = {tick_q, 1'b0};

  hpr_div #(
    .NUM_BITS (NUM_BITS),
    .DEN_BITS (DEN_BITS),
    .Q_BITS   (RPM_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .status_o (div_stat),
    .quot_o   (div_quot)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (capture) begin
          state_d = div_start ? ST_DIV : ST_WAIT;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output updates.
  always_comb begin
    tick_d      = tick_q;
    parity_d    = parity_q;
    latched_d   = latched_q;
    zero_pend_d = zero_pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    rpm_d       = rpm_q;
    zero_d      = zero_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (!in_op_i) begin
            // Timer tick: wrap to zero at or above the top value.
            if (tick_ext >= CNT_W'(top_q)) begin
              tick_d = '0;
            end else begin
              tick_d = tick_q + TIMER_BITS'(1);
            end
          end else if (latched_q) begin
            if (smp_ext <= LVL_W'(fall_q)) begin
              latched_d = 1'b0;
            end
          end else if (is_pass) begin
            latched_d = 1'b1;
            parity_d  = !parity_q;
            if (!parity_q) begin
              tick_d = '0;
            end else begin
              zero_pend_d = (tick_q == '0);
            end
          end
        end
      end
      ST_DIV: ;
      ST_WAIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          rpm_d       = zero_pend_q ? RPM_MAX : div_quot;
          zero_d      = zero_pend_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      parity_q    <= 1'b0;
      latched_q   <= 1'b0;
      state_q     <= ST_IDLE;
      zero_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tick_q      <= tick_d;
      parity_q    <= parity_d;
      latched_q   <= latched_d;
      state_q     <= state_d;
      zero_pend_q <= zero_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rpm_q  <= rpm_d;
    zero_q <= zero_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_rpm_o         = rpm_q;
  assign out_zero_period_o = zero_q;

  // The divider works exactly while the sequencer waits for it.
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy == (state_q == ST_DIV))
    else $error("divider activity and sequencer state disagree");

  // A new result is loaded only from the wait state.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q && out_stall_i)) |-> $past(state_q == ST_WAIT))
    else $error("result appeared outside the wait state");

  // A zero period always reports the saturated rpm.
  a_zero_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_zero_period_o) |-> (out_rpm_o == RPM_MAX))
    else $error("zero period without saturated rpm");

  // No input is taken while a measurement is being finished.
  a_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("input taken while busy");

endmodule

// ===== hw/rtl/hpr_div.sv =====
// ----------------------------------------------------------------------------
// hpr_div: iterative restoring divider
// Produces one quotient bit per cycle with one shared subtractor. The caller
// guarantees that the quotient fits Q_BITS bits.
// ----------------------------------------------------------------------------
module hpr_div
  import hpr_pkg::*;
#(
  parameter int unsigned NUM_BITS = 24,
  parameter int unsigned DEN_BITS = 17,
  parameter int unsigned Q_BITS   = 22
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_BITS-1:0] num_i,
  input  logic [DEN_BITS-1:0] den_i,
  output div_status_t         status_o,
  output logic [Q_BITS-1:0]   quot_o
);

  localparam int unsigned CNT_BITS = $clog2(Q_BITS + 1);

  logic                busy_q, busy_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [DEN_BITS-1:0] rem_q, rem_d;
  logic [DEN_BITS-1:0] den_q, den_d;
  logic [Q_BITS-1:0]   nq_q, nq_d;
  logic [DEN_BITS:0]   trial;
  logic                fits;

  // The remainder always stays below the divisor, so the shifted trial value
  // needs one extra bit only.
  assign trial = {rem_q, nq_q[Q_BITS-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    nq_d   = nq_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_BITS'(Q_BITS);
      rem_d  = DEN_BITS'(num_i >> Q_BITS);
      den_d  = den_i;
      nq_d   = num_i[Q_BITS-1:0];
    end else if (busy_q) begin
      rem_d = fits ? DEN_BITS'(trial - {1'b0, den_q}) : trial[DEN_BITS-1:0];
      nq_d  = {nq_q[Q_BITS-2:0], fits};
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    nq_q  <= nq_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = busy_q && (cnt_q == CNT_BITS'(1));
  assign quot_o        = nq_q;

endmodule

// ===== test/hpr_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hpr_tb_pkg: shared testbench codes of the hall pass rpm meter
// Names the two kinds of input request, so that stimulus and checking use
// the same codes.
// ----------------------------------------------------------------------------
package hpr_tb_pkg;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_SAMPLE = 1'b1
  } meter_op_e;

endpackage

// ===== test/hpr_rpm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hpr_rpm_checker: result checker of the hall pass rpm meter
// Watches the input, result and register channels, keeps its own copy of
// the tick counter, the pass parity and the magnet latch, predicts every rpm
// reading and compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module hpr_rpm_checker
  import hpr_pkg::*;
  import hpr_tb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  in_op_i,
  input  logic [LEVEL_BITS-1:0] in_sample_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [RPM_BITS-1:0]   out_rpm_i,
  input  logic                  out_zero_period_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  cfg_idx_e              cfg_index_i,
  input  logic [DATA_BITS-1:0]  cfg_data_i,
  input  logic                  close_i,
  output int unsigned           mismatches_o,
  output int unsigned           pending_o,
  output int unsigned           checked_o
);

  typedef struct packed {
    logic [RPM_BITS-1:0] rpm;
    logic                zero_period;
  } rpm_reading_t;

  logic [RATE_BITS-1:0]  tps_q;
  logic [LEVEL_BITS-1:0] rise_q;
  logic [LEVEL_BITS-1:0] fall_q;
  logic [TOP_BITS-1:0]   top_q;

  logic [TOP_BITS-1:0]   tick_cnt;
  logic                  second_pass;
  logic                  magnet_on;

  rpm_reading_t          rpm_due[$];
  int unsigned           mismatches = 0;
  int unsigned           checked = 0;
  bit                    closed = 1'b0;

  task automatic report_mismatch(input string what);
    $display("[%0t] rpm meter check failed: %s", $time, what);
    mismatches++;
  endtask

  // Advances the tachometer state by one accepted request and queues the
  // reading that a second magnet pass produces.
  task automatic update_tachometer(input meter_op_e op, input logic [LEVEL_BITS-1:0] level);
    rpm_reading_t reading;
    logic [31:0]  scaled;
    logic [31:0]  quotient;
    if (op == OP_TICK) begin
      if (tick_cnt >= top_q) tick_cnt = '0;
      else tick_cnt = tick_cnt + TOP_BITS'(1);
    end else if (magnet_on) begin
      if (level <= fall_q) magnet_on = 1'b0;
    end else if (level >= rise_q) begin
      magnet_on = 1'b1;
      if (!second_pass) begin
        second_pass = 1'b1;
        tick_cnt = '0;
      end else begin
        second_pass = 1'b0;
        if (tick_cnt == '0) begin
          reading.rpm = RPM_MAX;
          reading.zero_period = 1'b1;
        end else begin
          // Round half up: (120 * rate + period) / (2 * period).
          scaled = 32'(RPM_SCALE) * 32'(tps_q) + 32'(tick_cnt);
          quotient = scaled / (32'(tick_cnt) << 1);
          if (quotient > 32'(RPM_MAX)) quotient = 32'(RPM_MAX);
          reading.rpm = quotient[RPM_BITS-1:0];
          reading.zero_period = 1'b0;
        end
        rpm_due.push_back(reading);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rpm_reading_t want;
    if (!rst_ni) begin
      tps_q = TPS_RESET;
      rise_q = RISE_RESET;
      fall_q = FALL_RESET;
      top_q = TOP_RESET;
      tick_cnt = '0;
      second_pass = 1'b0;
      magnet_on = 1'b0;
      rpm_due.delete();
    end else begin
      // Results are compared before this edge's request is predicted, since a
      // reading never leaves in the cycle of the pass that causes it.
      if (out_valid_i && !out_stall_i) begin
        if (rpm_due.size() == 0) begin
          report_mismatch($sformatf("rpm %0d delivered with no reading due", out_rpm_i));
        end else begin
          want = rpm_due.pop_front();
          checked++;
          if (out_rpm_i !== want.rpm)
            report_mismatch($sformatf("rpm %0d, predicted %0d", out_rpm_i, want.rpm));
          if (out_zero_period_i !== want.zero_period)
            report_mismatch($sformatf("zero_period %0b, predicted %0b",
                                      out_zero_period_i, want.zero_period));
        end
      end
      if (in_valid_i && !in_stall_i) update_tachometer(meter_op_e'(in_op_i), in_sample_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TPS:  tps_q = cfg_data_i[RATE_BITS-1:0];
          CFG_RISE: rise_q = cfg_data_i[LEVEL_BITS-1:0];
          CFG_FALL: fall_q = cfg_data_i[LEVEL_BITS-1:0];
          CFG_TOP:  top_q = cfg_data_i[TOP_BITS-1:0];
          default: ;
        endcase
      end
      if (close_i && !closed) begin
        closed = 1'b1;
        while (rpm_due.size() != 0) begin
          want = rpm_due.pop_front();
          report_mismatch($sformatf("predicted rpm %0d never delivered", want.rpm));
        end
      end
    end
    mismatches_o <= mismatches;
    pending_o <= rpm_due.size();
    checked_o <= checked;
  end

endmodule

// ===== test/tb_hall_pass_rpm_meter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hall_pass_rpm_meter: testbench of the hall pass rpm meter
// Drives timer ticks and sensor samples shaped as magnet revolutions under a
// series of register settings, with random idling on both channels and one
// long receiver hold-off; a checker beside the block predicts every reading.
// ----------------------------------------------------------------------------
module tb_hall_pass_rpm_meter;
  import hpr_pkg::*;
  import hpr_tb_pkg::*;

  // The receiver hold-off is long enough for the result register to fill and
  // the block to stall its input; the watchdog limit lies above it.
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Long enough for the divider to finish any reading still in flight.
  localparam int unsigned QUIET_CYCLES   = 30;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  in_op_i;
  logic [LEVEL_BITS-1:0] in_sample_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [RPM_BITS-1:0]   out_rpm_o;
  logic                  out_zero_period_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  cfg_idx_e              cfg_index_i;
  logic [DATA_BITS-1:0]  cfg_data_i;
  logic                  close_i;

  int unsigned           mismatches;
  int unsigned           pending;
  int unsigned           checked;

  // Shared between the stimulus and the receiver process: a request for the
  // long hold-off, and the final stretch in which neither side idles.
  bit                    hold_request = 1'b0;
  bit                    calm = 1'b0;

  // Thresholds of the current setting, used to shape the samples.
  int unsigned           cur_rise = 450;
  int unsigned           cur_fall = 417;
  int unsigned           sent_count = 0;
  int unsigned           setting_count = 1;
  int unsigned           quiet_cycles = 0;

  hall_pass_rpm_meter dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_op_i           (in_op_i),
    .in_sample_i       (in_sample_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_rpm_o         (out_rpm_o),
    .out_zero_period_o (out_zero_period_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  hpr_rpm_checker checker_inst (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .in_op_i           (in_op_i),
    .in_sample_i       (in_sample_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_rpm_i         (out_rpm_o),
    .out_zero_period_i (out_zero_period_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .close_i           (close_i),
    .mismatches_o      (mismatches),
    .pending_o         (pending),
    .checked_o         (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The watchdog restarts on every handshake of any channel. Reaching the
  // limit means the block has hung, and the run ends as a failure.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < WATCHDOG_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("Watchdog expired after %0d cycles without a handshake", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver. It stalls in random bursts, holds off for a
  // long stretch once when asked, and never stalls in the final stretch.
  initial begin
    int unsigned burst;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (calm) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        burst = $urandom_range(1, 16);
        out_stall_i <= ($urandom_range(0, 2) == 0);
        repeat (burst) @(posedge clk_i);
      end
    end
  end

  // Offers one request and holds it until the block takes it. Outside the
  // final stretch the sender then pauses now and then.
  task automatic send_request(input meter_op_e op, input int unsigned level);
    in_valid_i <= 1'b1;
    in_op_i <= op;
    in_sample_i <= LEVEL_BITS'(level);
    do @(posedge clk_i); while (in_stall_o);
    sent_count++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // Waits until every predicted reading has been delivered, then lets the
  // block run dry before anything else happens.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [DATA_BITS-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Registers are only written while the block is idle.
  task automatic apply_setting(input int unsigned tps, input int unsigned rise,
                               input int unsigned fall, input int unsigned top);
    settle();
    write_reg(CFG_TPS, DATA_BITS'(tps));
    write_reg(CFG_RISE, DATA_BITS'(rise));
    write_reg(CFG_FALL, DATA_BITS'(fall));
    write_reg(CFG_TOP, DATA_BITS'(top));
    cur_rise = rise;
    cur_fall = fall;
    setting_count++;
  endtask

  // One magnet pass: the sample that detects it, a few samples that the
  // latch ignores, the sample that ends it, then the ticks of the period,
  // sprinkled with samples too weak to count as a pass.
  task automatic magnet_pass(input int unsigned ticks);
    send_request(OP_SAMPLE, $urandom_range(cur_rise, 1023));
    if (cur_fall < 1023)
      repeat ($urandom_range(0, 2)) send_request(OP_SAMPLE, $urandom_range(cur_fall + 1, 1023));
    send_request(OP_SAMPLE, $urandom_range(0, cur_fall));
    repeat (ticks) begin
      if (cur_rise > 0 && $urandom_range(0, 7) == 0)
        send_request(OP_SAMPLE, $urandom_range(0, cur_rise - 1));
      send_request(OP_TICK, $urandom_range(0, 1023));
    end
  endtask

  // Mostly well-formed revolutions with short periods, some zero periods
  // and a few long ones, mixed with fully random requests that may form or
  // break a pass. The budget counts every request sent.
  task automatic run_phase(input int unsigned budget);
    int unsigned start;
    int unsigned ticks;
    start = sent_count;
    while (sent_count - start < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(meter_op_e'($urandom_range(0, 1)), $urandom_range(0, 1023));
      end else begin
        case ($urandom_range(0, 31))
          0, 1:    ticks = 0;
          2:       ticks = $urandom_range(50, 300);
          default: ticks = $urandom_range(1, 16);
        endcase
        magnet_pass(ticks);
      end
    end
  endtask

  initial begin
    int unsigned rise;
    in_valid_i <= 1'b0;
    in_op_i <= OP_TICK;
    in_sample_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_TPS;
    cfg_data_i <= '0;
    close_i <= 1'b0;
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset setting (rate 12000, levels 450 and 417).
    // Ticks carry extreme sample values, which must be ignored.
    send_request(OP_TICK, 1023);
    send_request(OP_TICK, 0);
    send_request(OP_SAMPLE, 449);   // just below the rise level
    send_request(OP_SAMPLE, 450);   // first pass, clears the counter
    send_request(OP_SAMPLE, 1023);  // latched, ignored
    send_request(OP_SAMPLE, 418);   // still above the fall level
    send_request(OP_SAMPLE, 417);   // exactly at the fall level, unlatches
    send_request(OP_SAMPLE, 0);
    send_request(OP_TICK, 32'h2AA);
    send_request(OP_TICK, 32'h155);
    send_request(OP_TICK, 32'h3FF);
    send_request(OP_SAMPLE, 1023);  // second pass, period of three ticks
    send_request(OP_SAMPLE, 417);
    send_request(OP_SAMPLE, 600);   // first pass
    send_request(OP_SAMPLE, 0);
    send_request(OP_SAMPLE, 450);   // second pass with no tick between
    send_request(OP_SAMPLE, 200);
    send_request(OP_SAMPLE, 451);   // first pass
    send_request(OP_SAMPLE, 3);
    send_request(OP_TICK, 0);
    send_request(OP_SAMPLE, 1000);  // one-tick period, the highest rpm of any nonzero period here
    send_request(OP_SAMPLE, 417);

    // Reset setting, random part. Midway the receiver holds off for a long
    // stretch while the sender keeps offering, so the block backs up.
    run_phase(120);
    hold_request = 1'b1;
    run_phase(130);

    // Top extremes: fastest rate, passes only at full scale, latch cleared
    // only by a zero sample.
    apply_setting(65535, 1023, 0, 65535);
    run_phase(200);

    // Bottom extremes: rate one, every unlatched sample a pass, every latched
    // sample an unlatch, and a counter that wraps after one.
    apply_setting(1, 0, 1023, 1);
    run_phase(150);

    // Zero rate with nonzero periods, a rise level below the fall level so a
    // pass sample may itself lie under the fall level, and frequent wraps.
    apply_setting(0, 300, 600, 7);
    run_phase(150);

    // Counter held at zero: every reading is a zero period.
    rise = $urandom_range(1, 1023);
    apply_setting($urandom_range(1, 65535), rise, $urandom_range(0, 1023), 0);
    run_phase(100);

    // Random rate and levels and a wrapping counter.
    rise = $urandom_range(1, 1023);
    apply_setting($urandom_range(1, 65535), rise, $urandom_range(0, rise - 1), 20);
    run_phase(250);

    // Final stretch with no idling on either side.
    rise = $urandom_range(1, 1023);
    apply_setting($urandom_range(1, 65535), rise, $urandom_range(0, rise - 1),
                  $urandom_range(30, 65535));
    calm = 1'b1;
    run_phase(300);

    settle();
    close_i <= 1'b1;
    repeat (2) @(posedge clk_i);

    $display("Run drove %0d requests under %0d register settings, one long receiver hold-off",
             sent_count, setting_count);
    $display("%0d rpm readings compared, zero periods and a zero rate among them", checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
